[design/lcdnpw_pkg.sv]
// Shared constants, types and functions for the LCD number position writer.
`timescale 1ns / 1ps
package lcdnpw_pkg;

  localparam int NUM_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int DIG_IDX_W  = $clog2(BCD_DIGITS + 1);

  localparam int MAX_DIGITS_DEF      = 10;
  localparam int DISPLAY_COLUMNS_DEF = 16;
  localparam int DISPLAY_ROWS_DEF    = 4;

  localparam logic [7:0] ROW1_BASE   = 8'h80;
  localparam logic [7:0] ROW2_BASE   = 8'hC0;
  localparam logic [7:0] ROW3_BASE   = 8'h90;
  localparam logic [7:0] ROW4_BASE   = 8'hD0;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic       cmd_en;
    logic [7:0] cmd_byte;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] row_idx);
    logic [7:0] b;
    case (row_idx)
      2'd0:    b = ROW1_BASE;
      2'd1:    b = ROW2_BASE;
      2'd2:    b = ROW3_BASE;
      default: b = ROW4_BASE;
    endcase
    return b;
  endfunction

  // Number of significant decimal digits, at least one.
  function automatic logic [DIG_IDX_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [DIG_IDX_W-1:0] n;
    n = DIG_IDX_W'(1);
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        n = DIG_IDX_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[design/lcdnpw_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`timescale 1ns / 1ps
module lcdnpw_dabble
  import lcdnpw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [NUM_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = number;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
      bin_nxt  = {bin_r[NUM_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[design/lcdnpw_emit.sv]
// Write sequencer: optional cursor command, digits most significant first, optional space.
`timescale 1ns / 1ps
module lcdnpw_emit
  import lcdnpw_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  job_t             job,
  input  logic [BCD_W-1:0] bcd,
  output logic             finish,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_character,
  output logic [7:0]       out_bus_byte,
  output logic             out_last_write
);

  typedef enum logic [1:0] {E_IDLE, E_CMD, E_DIG, E_SPC} state_t;

  state_t               state_r;
  logic [DIG_IDX_W-1:0] idx_r;
  logic                 space_r;
  logic                 valid_r;
  logic                 is_char_r;
  logic [7:0]           byte_r;
  logic                 last_r;

  logic                 ld;
  logic [DIG_IDX_W-1:0] ndig;
  logic [DIG_IDX_W-1:0] shown;
  logic [3:0]           digit;

  assign ld    = !valid_r || !out_stall;
  assign ndig  = digit_count(bcd);
  assign shown = (5'(MAX_DIGITS) < 5'(ndig)) ? DIG_IDX_W'(MAX_DIGITS) : ndig;
  assign digit = bcd[4*idx_r +: 4];

  assign finish = ld && ((state_r == E_SPC) ||
                         (state_r == E_DIG && idx_r == '0 && !space_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (ld) begin
            valid_r <= 1'b0;
          end
          if (start) begin
            idx_r   <= shown - DIG_IDX_W'(1);
            space_r <= (ndig <= DIG_IDX_W'(2));
            state_r <= job.cmd_en ? E_CMD : E_DIG;
          end
        end
        E_CMD: begin
          if (ld) begin
            valid_r   <= 1'b1;
            is_char_r <= 1'b0;
            byte_r    <= job.cmd_byte;
            last_r    <= 1'b0;
            state_r   <= E_DIG;
          end
        end
        E_DIG: begin
          if (ld) begin
            valid_r   <= 1'b1;
            is_char_r <= 1'b1;
            byte_r    <= ASCII_ZERO | {4'd0, digit};
            last_r    <= (idx_r == '0) && !space_r;
            if (idx_r == '0) begin
              state_r <= space_r ? E_SPC : E_IDLE;
            end else begin
              idx_r <= idx_r - DIG_IDX_W'(1);
            end
          end
        end
        E_SPC: begin
          if (ld) begin
            valid_r   <= 1'b1;
            is_char_r <= 1'b1;
            byte_r    <= ASCII_SPACE;
            last_r    <= 1'b1;
            state_r   <= E_IDLE;
          end
        end
        default: begin
          valid_r <= 1'b0;
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = valid_r;
  assign out_is_character = is_char_r;
  assign out_bus_byte     = byte_r;
  assign out_last_write   = last_r;

endmodule

[design/lcd_number_position_writer_core.sv]
// Top level of the LCD number position writer.
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction: row, column and a
//   32-bit unsigned number. Result channel (out_valid/out_stall) carries LCD bus
//   writes: register select, data byte and a last-write flag.
//   A cursor command is written first when row and column are on the display,
//   then the decimal digits most significant first, then a space for numbers of
//   one or two digits.
// Timing:
//   One item at a time. After acceptance the binary to BCD converter takes
//   one input bit per cycle, then writes go out one per cycle while the
//   output is not stalled, up to 11 writes per item. in_stall stays high from
//   acceptance until the last write is loaded into the output register.
// Reset clears all control state; no transaction is pending afterward.
// A stalled output holds its write, and the sequencer waits.
`timescale 1ns / 1ps
module lcd_number_position_writer_core
  import lcdnpw_pkg::*;
#(
  parameter int MAX_DIGITS      = MAX_DIGITS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_row,
  input  logic [4:0]       in_column,
  input  logic [NUM_W-1:0] in_number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_character,
  output logic [7:0]       out_bus_byte,
  output logic             out_last_write
);

  logic             busy_r, busy_nxt;
  job_t             job_r;
  logic             accept;
  logic             pos_ok;
  logic             conv_done;
  logic             finish;
  logic [BCD_W-1:0] bcd;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  assign pos_ok = (in_row != 3'd0) && (in_row <= 3'(DISPLAY_ROWS)) &&
                  (in_column != 5'd0) && ({1'b0, in_column} <= 6'(DISPLAY_COLUMNS));

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.cmd_en   <= pos_ok;
      job_r.cmd_byte <= row_base(2'(in_row - 3'd1)) + {3'd0, in_column - 5'd1};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  lcdnpw_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .number (in_number),
    .done   (conv_done),
    .bcd    (bcd)
  );

  lcdnpw_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (conv_done),
    .job              (job_r),
    .bcd              (bcd),
    .finish           (finish),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_character (out_is_character),
    .out_bus_byte     (out_bus_byte),
    .out_last_write   (out_last_write)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the LCD number position writer core.
`timescale 1ns / 1ps
module tb;
  import lcdnpw_pkg::*;

  localparam int N_RANDOM    = 130;
  localparam int IDLE_PCT    = 27;
  localparam int QUIET_FIRST = 4000;
  localparam int QUIET_LAST  = 6500;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 60;

  localparam int SHOW_DIGITS = 10;
  localparam int LCD_COLS    = 16;
  localparam int LCD_ROWS    = 4;
  localparam logic [7:0] CUR_ROW1  = 8'h80;
  localparam logic [7:0] CUR_ROW2  = 8'hC0;
  localparam logic [7:0] CUR_ROW3  = 8'h90;
  localparam logic [7:0] CUR_ROW4  = 8'hD0;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  typedef struct packed {
    logic [2:0]       row;
    logic [4:0]       column;
    logic [NUM_W-1:0] number;
  } pos_req_t;

  typedef struct packed {
    logic       is_character;
    logic [7:0] bus_byte;
    logic       last_write;
  } lcd_write_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       in_row = '0;
  logic [4:0]       in_column = '0;
  logic [NUM_W-1:0] in_number = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_is_character;
  logic [7:0]       out_bus_byte;
  logic             out_last_write;

  pos_req_t   req_q[$];
  lcd_write_t lcd_write_q[$];
  int         err_cnt = 0;
  int         cyc = 0;
  int         hold_cnt = 0;
  logic       hold_active = 1'b0;
  logic       quiet;

  lcd_number_position_writer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_character (out_is_character),
    .out_bus_byte     (out_bus_byte),
    .out_last_write   (out_last_write)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign quiet = (cyc >= QUIET_FIRST) && (cyc <= QUIET_LAST);

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_cnt++;
  endtask

  // Expected LCD writes per request: optional cursor cmd, digits, maybe blank.
  task automatic predict_lcd_writes(input pos_req_t r);
    logic [3:0]  dig [0:9];
    logic        is_c [0:11];
    logic [7:0]  byt [0:11];
    logic [31:0] v;
    logic [7:0]  base;
    int          ndig;
    int          shown;
    int          k;
    v = r.number;
    dig[0] = 4'(v % 10);
    v = v / 10;
    ndig = 1;
    while (v != 0) begin
      dig[ndig] = 4'(v % 10);
      v = v / 10;
      ndig++;
    end
    k = 0;
    if (r.row >= 1 && r.row <= LCD_ROWS && r.column >= 1 && r.column <= LCD_COLS) begin
      case (r.row)
        3'd1:    base = CUR_ROW1;
        3'd2:    base = CUR_ROW2;
        3'd3:    base = CUR_ROW3;
        default: base = CUR_ROW4;
      endcase
      is_c[k] = 1'b0;
      byt[k]  = base + 8'(r.column - 1);
      k++;
    end
    shown = (ndig > SHOW_DIGITS) ? SHOW_DIGITS : ndig;
    for (int i = shown - 1; i >= 0; i--) begin
      is_c[k] = 1'b1;
      byt[k]  = CHAR_ZERO + 8'(dig[i]);
      k++;
    end
    if (ndig <= 2) begin
      is_c[k] = 1'b1;
      byt[k]  = CHAR_BLANK;
      k++;
    end
    for (int i = 0; i < k; i++) begin
      lcd_write_q.push_back({is_c[i], byt[i], (i == k - 1)});
    end
  endtask

  function automatic logic [31:0] number_of_len(input int len);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = 1;
    for (int i = 1; i < len; i++) begin
      lo = lo * 10;
    end
    hi = (len == 10) ? 32'hFFFF_FFFF : lo * 10 - 1;
    if (len == 1) begin
      lo = 0;
    end
    return $urandom_range(hi, lo);
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_lcd_writes(req_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          in_row    <= req_q[0].row;
          in_column <= req_q[0].column;
          in_number <= req_q[0].number;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the core backs up onto its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt    <= 0;
      hold_active <= 1'b0;
    end else if (cyc == HOLD_START) begin
      hold_cnt    <= HOLD_LEN;
      hold_active <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) begin
        hold_active <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_active || (!quiet && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor
  always @(posedge clk) begin : mon
    lcd_write_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_write_q.size() == 0) begin
        report_mismatch($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                  out_is_character, out_bus_byte, out_last_write));
      end else begin
        exp_w = lcd_write_q.pop_front();
        if (out_is_character !== exp_w.is_character) begin
          report_mismatch($sformatf("is_character %0b, expected %0b",
                                    out_is_character, exp_w.is_character));
        end
        if (out_bus_byte !== exp_w.bus_byte) begin
          report_mismatch($sformatf("bus_byte %02h, expected %02h",
                                    out_bus_byte, exp_w.bus_byte));
        end
        if (out_last_write !== exp_w.last_write) begin
          report_mismatch($sformatf("last_write %0b, expected %0b",
                                    out_last_write, exp_w.last_write));
        end
      end
    end
  end

  initial begin
    pos_req_t r;
    req_q.push_back('{3'd1, 5'd1,  32'd0});
    req_q.push_back('{3'd4, 5'd16, 32'hFFFF_FFFF});
    req_q.push_back('{3'd2, 5'd5,  32'd9});
    req_q.push_back('{3'd3, 5'd10, 32'd10});
    req_q.push_back('{3'd1, 5'd16, 32'd99});
    req_q.push_back('{3'd4, 5'd1,  32'd100});
    req_q.push_back('{3'd0, 5'd5,  32'd7});
    req_q.push_back('{3'd5, 5'd3,  32'd12});
    req_q.push_back('{3'd7, 5'd31, 32'd123});
    req_q.push_back('{3'd2, 5'd0,  32'd5});
    req_q.push_back('{3'd3, 5'd17, 32'd42});
    req_q.push_back('{3'd1, 5'd31, 32'd1000000000});
    req_q.push_back('{3'd4, 5'd16, 32'd999999999});
    req_q.push_back('{3'd2, 5'd8,  32'd1234567890});
    req_q.push_back('{3'd6, 5'd16, 32'd0});
    req_q.push_back('{3'd0, 5'd0,  32'hFFFF_FFFF});
    req_q.push_back('{3'd3, 5'd2,  32'd55});
    req_q.push_back('{3'd1, 5'd2,  32'd3});
    req_q.push_back('{3'd2, 5'd16, 32'd65535});
    req_q.push_back('{3'd4, 5'd15, 32'h8000_0000});
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(99) < 80) begin
        r.row    = 3'($urandom_range(4, 1));
        r.column = 5'($urandom_range(16, 1));
      end else begin
        r.row    = 3'($urandom_range(7, 0));
        r.column = 5'($urandom_range(31, 0));
      end
      r.number = ($urandom_range(99) < 25) ? $urandom : number_of_len($urandom_range(10, 1));
      req_q.push_back(r);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (lcd_write_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** lcd_number_position_writer_core: PASSED **");
    end else begin
      $display("** lcd_number_position_writer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("** lcd_number_position_writer_core: FAILED **");
    $finish;
  end

endmodule
